// ===== rtl/avsda_pkg.sv =====
`default_nettype none

package avsda_pkg;

   // Sizing
   localparam int WINDOW_SAMPLES = 32;   // power of two, mean is a shift
   localparam int RING_SLOTS     = 16;
   localparam int EYE_COUNT      = 2;

   localparam int WIN_BITS  = $clog2(WINDOW_SAMPLES);
   localparam int SLOT_BITS = 4;
   localparam int EYE_BITS  = 1;

   localparam int TIME_W   = 35;
   localparam int NOW_W    = 44;
   localparam int FT_W     = 14;
   localparam int SAMPLE_W = 36;
   localparam int SUM_W    = SAMPLE_W + WIN_BITS;
   localparam int BUF_W    = NOW_W + 2;   // fill * frame time plus time left of frame
   localparam int CALC_W   = BUF_W + 2;   // signed headroom for audio - video + buffered

   typedef enum logic [1:0] {
      CMD_RECORD = 2'd0,
      CMD_UPDATE = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic {
      CSR_FRAME_TIME_LEFT  = 1'b0,
      CSR_FRAME_TIME_RIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      cmd_type                 cmd;
      logic [EYE_BITS-1:0]     eye;
      logic [SLOT_BITS-1:0]    slot;
      logic [TIME_W-1:0]       frame_pts;
      logic                    frame_pts_valid;
      logic [SLOT_BITS-1:0]    store_index;
      logic [SLOT_BITS-1:0]    draw_index;
      logic [NOW_W-1:0]        now_time;
      logic [NOW_W-1:0]        last_frame_time;
      logic [TIME_W-1:0]       audio_position;
      logic [TIME_W-1:0]       video_position;
   } req_type;

   typedef struct packed {
      logic [EYE_BITS-1:0]        result_eye;
      logic signed [SAMPLE_W-1:0] delay_sample;
      logic signed [SAMPLE_W-1:0] average_delay;
   } rsp_type;

   // Control from the item pipeline to the delay window
   typedef struct packed {
      logic                rd_en;     // item accepted, fetch its old window sample
      logic [EYE_BITS-1:0] rd_eye;
      logic                push;      // update item retires this cycle
      logic [EYE_BITS-1:0] push_eye;
      logic                clear;     // clear item retires this cycle
   } win_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/avsda_window.sv =====
`default_nettype none

module avsda_window (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire avsda_pkg::win_ctrl_type              ctrl,
   input  wire logic signed [avsda_pkg::SAMPLE_W-1:0] sample,
   output logic signed [avsda_pkg::SAMPLE_W-1:0]      average
);
   import avsda_pkg::*;

   logic [SAMPLE_W-1:0]       win_mem [EYE_COUNT][WINDOW_SAMPLES];
   logic                      win_valid_ff [EYE_COUNT][WINDOW_SAMPLES];
   logic [WIN_BITS-1:0]       head_ff [EYE_COUNT];
   logic signed [SUM_W-1:0]   sum_ff [EYE_COUNT];
   logic [SAMPLE_W-1:0]       rd_data_ff;

   logic [WIN_BITS-1:0]       rd_head;
   logic [WIN_BITS-1:0]       push_head;
   logic signed [SAMPLE_W-1:0] old_sample;
   logic signed [SUM_W-1:0]   sum_in;

   // Head seen by the incoming item, after whatever retires this cycle
   always_comb begin
      rd_head = head_ff[ctrl.rd_eye];
      if (ctrl.clear) begin
         rd_head = '0;
      end else if (ctrl.push && (ctrl.push_eye == ctrl.rd_eye)) begin
         rd_head = head_ff[ctrl.rd_eye] + 1'b1;
      end
   end

   assign push_head  = head_ff[ctrl.push_eye];
   assign old_sample = win_valid_ff[ctrl.push_eye][push_head] ? $signed(rd_data_ff) : '0;
   assign sum_in     = sum_ff[ctrl.push_eye] + SUM_W'(sample) - SUM_W'(old_sample);
   assign average    = SAMPLE_W'(sum_in >>> WIN_BITS);

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_data_ff <= win_mem[ctrl.rd_eye][rd_head];
      end
      if (ctrl.push) begin
         win_mem[ctrl.push_eye][push_head] <= sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         for (int e = 0; e < EYE_COUNT; e++) begin
            head_ff[e] <= '0;
            sum_ff[e]  <= '0;
            for (int i = 0; i < WINDOW_SAMPLES; i++) begin
               win_valid_ff[e][i] <= 1'b0;
            end
         end
      end else if (ctrl.push) begin
         head_ff[ctrl.push_eye]                <= push_head + 1'b1;
         sum_ff[ctrl.push_eye]                 <= sum_in;
         win_valid_ff[ctrl.push_eye][push_head] <= 1'b1;
      end
   end

   a_clear_eye0: assert property (@(posedge clock) disable iff (reset)
      ctrl.clear |=> (head_ff[0] == '0) && (sum_ff[0] == '0))
      else $error("window of first eye not cleared");

   a_clear_last: assert property (@(posedge clock) disable iff (reset)
      ctrl.clear |=> (head_ff[EYE_COUNT-1] == '0) && (sum_ff[EYE_COUNT-1] == '0))
      else $error("window of last eye not cleared");

   a_push_head: assert property (@(posedge clock) disable iff (reset)
      (ctrl.push && !ctrl.clear) |=>
         head_ff[$past(ctrl.push_eye)] == WIN_BITS'($past(head_ff[ctrl.push_eye]) + 1'b1))
      else $error("window head did not advance on push");

endmodule

`default_nettype wire

// ===== rtl/av_sync_delay_averager.sv =====
`default_nettype none

// Audio/video delay averager, one channel per eye.
//
// req_*  : command items (record slot time, delay update, clear all).
// rsp_*  : one item per update command: eye, new delay sample, window mean.
// csr_*  : frame durations per eye, to be written only while the block is
//          idle; the user must keep to this, the block does not enforce it.
// Path: an accepted update item goes through the stage register and the
// result register to rsp_*. Throughput: one item per cycle unless stalled.
// The work is one pass of logic between the two; the window memory read is
// issued at accept time, so it is ready when the item reaches the stage.
//
// Reset: all slot times invalid, windows and running sums zero, frame times
// zero. A clear item does the same except for frame times.
//
// Stall: when rsp_ready is low and a result is waiting, an update item in
// the stage holds and req_ready drops; record and clear items still retire.
module av_sync_delay_averager (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request channel
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire avsda_pkg::req_type      req_data,
   // result channel
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output avsda_pkg::rsp_type           rsp_data,
   // configuration
   input  wire logic                    csr_write_en,
   input  wire avsda_pkg::csr_index_type csr_index,
   input  wire logic [avsda_pkg::FT_W-1:0] csr_wdata
);
   import avsda_pkg::*;

   // configuration
   logic [FT_W-1:0]   ft_left_ff;
   logic [FT_W-1:0]   ft_right_ff;

   // stage register
   logic              s1_valid_ff;
   logic              s1_valid_in;
   req_type           s1_item_ff;

   // result register
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rsp_type           rsp_data_ff;

   // presentation time per slot and eye
   logic              pts_valid_ff [RING_SLOTS][EYE_COUNT];
   logic [TIME_W-1:0] pts_time_ff  [RING_SLOTS][EYE_COUNT];

   logic              out_free;
   logic              s1_update;
   logic              s1_go;
   logic              req_accept;

   logic [FT_W-1:0]       ft;
   logic [SLOT_BITS-1:0]  fill;
   logic [SLOT_BITS-1:0]  shown;
   logic [NOW_W:0]        due;
   logic [NOW_W:0]        frame_left;
   logic [BUF_W-1:0]      buffered;
   logic signed [CALC_W-1:0] est;
   logic signed [SAMPLE_W-1:0] sample;
   logic signed [SAMPLE_W-1:0] average;
   win_ctrl_type          win_ctrl;

   // ---------------- handshake ----------------
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s1_update  = (s1_item_ff.cmd == CMD_UPDATE);
   assign s1_go      = s1_valid_ff && (!s1_update || out_free);
   assign req_ready  = !s1_valid_ff || s1_go;
   assign req_accept = req_valid && req_ready;

   assign s1_valid_in  = req_accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = out_free ? (s1_go && s1_update) : rsp_valid_ff;

   // ---------------- delay sample ----------------
   always_comb begin
      ft = (s1_item_ff.eye == '0) ? ft_left_ff : ft_right_ff;

      // ring fill, mod RING_SLOTS
      if (s1_item_ff.store_index >= s1_item_ff.draw_index) begin
         fill = s1_item_ff.store_index - s1_item_ff.draw_index;
      end else begin
         fill = SLOT_BITS'((SLOT_BITS+1)'(s1_item_ff.store_index) + (SLOT_BITS+1)'(RING_SLOTS)
                - (SLOT_BITS+1)'(s1_item_ff.draw_index));
      end

      // slot on screen: one behind the draw index
      if (s1_item_ff.draw_index == '0) begin
         shown = SLOT_BITS'(RING_SLOTS - 1);
      end else begin
         shown = s1_item_ff.draw_index - 1'b1;
      end

      // time still left of the frame on screen
      due = (NOW_W+1)'(s1_item_ff.last_frame_time) + (NOW_W+1)'(ft);
      if (due > (NOW_W+1)'(s1_item_ff.now_time)) begin
         frame_left = due - (NOW_W+1)'(s1_item_ff.now_time);
      end else begin
         frame_left = '0;
      end

      // full-width product of ring fill and frame time
      buffered = BUF_W'((FT_W+SLOT_BITS)'(fill) * (FT_W+SLOT_BITS)'(ft))
               + BUF_W'(frame_left);

      if (pts_valid_ff[shown][s1_item_ff.eye]) begin
         est = $signed(CALC_W'(s1_item_ff.audio_position))
             - $signed(CALC_W'(pts_time_ff[shown][s1_item_ff.eye]));
      end else begin
         est = $signed(CALC_W'(s1_item_ff.audio_position))
             - $signed(CALC_W'(s1_item_ff.video_position))
             + $signed(CALC_W'(buffered));
      end

      // saturate to the result width
      if (est[CALC_W-1:SAMPLE_W-1] == '0 || est[CALC_W-1:SAMPLE_W-1] == '1) begin
         sample = est[SAMPLE_W-1:0];
      end else if (est[CALC_W-1]) begin
         sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
   end

   // ---------------- sliding window ----------------
   always_comb begin
      win_ctrl.rd_en    = req_accept && (req_data.cmd == CMD_UPDATE);
      win_ctrl.rd_eye   = req_data.eye;
      win_ctrl.push     = s1_go && s1_update;
      win_ctrl.push_eye = s1_item_ff.eye;
      win_ctrl.clear    = s1_go && (s1_item_ff.cmd == CMD_CLEAR);
   end

   avsda_window u_window (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (win_ctrl),
      .sample  (sample),
      .average (average)
   );

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         ft_left_ff  <= '0;
         ft_right_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_FRAME_TIME_LEFT:  ft_left_ff  <= csr_wdata;
            CSR_FRAME_TIME_RIGHT: ft_right_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= req_data;
      end
      if (s1_go && s1_update) begin
         rsp_data_ff.result_eye    <= s1_item_ff.eye;
         rsp_data_ff.delay_sample  <= sample;
         rsp_data_ff.average_delay <= average;
      end
   end

   // slot times: valid bits clear on reset and on a clear item
   always_ff @(posedge clock) begin
      if (reset || (s1_go && s1_item_ff.cmd == CMD_CLEAR)) begin
         for (int s = 0; s < RING_SLOTS; s++) begin
            for (int e = 0; e < EYE_COUNT; e++) begin
               pts_valid_ff[s][e] <= 1'b0;
            end
         end
      end else if (s1_go && s1_item_ff.cmd == CMD_RECORD) begin
         pts_valid_ff[s1_item_ff.slot][s1_item_ff.eye] <= s1_item_ff.frame_pts_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_item_ff.cmd == CMD_RECORD) begin
         pts_time_ff[s1_item_ff.slot][s1_item_ff.eye] <= s1_item_ff.frame_pts;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- checks ----------------
   a_update_result: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_update) |=> rsp_valid_ff)
      else $error("retired update produced no result");

   a_other_no_result: assert property (@(posedge clock) disable iff (reset)
      (s1_go && !s1_update) |=> (rsp_valid_ff == $past(rsp_valid_ff && !rsp_ready)))
      else $error("non-update item produced a result");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |=> (s1_valid_ff && $stable(s1_item_ff)))
      else $error("stalled stage item changed");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none

module tb_top;
   import avsda_pkg::*;

   // Quiet cycles (nothing accepted on either channel) before the run is
   // declared hung. Covers the long result hold-off plus idle bursts.
   localparam int STALL_LIMIT = 2000;

   // Saturation bounds of one delay sample
   localparam longint SAMPLE_HI = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
   localparam longint SAMPLE_LO = -(longint'(1) <<< (SAMPLE_W - 1));

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   req_type       req_data;
   logic          rsp_valid;
   logic          rsp_ready;
   rsp_type       rsp_data;
   logic          csr_write_en;
   csr_index_type csr_index;
   logic [FT_W-1:0] csr_wdata;

   av_sync_delay_averager u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // ------------------------------------------------------------------
   // Delay predictor state: per-eye slot times, sample window, running sum
   // ------------------------------------------------------------------
   logic              slot_pts_valid [EYE_COUNT][RING_SLOTS];
   logic [TIME_W-1:0] slot_pts       [EYE_COUNT][RING_SLOTS];
   longint            delay_hist     [EYE_COUNT][WINDOW_SAMPLES];
   int                hist_head      [EYE_COUNT];
   longint            hist_sum       [EYE_COUNT];
   logic [FT_W-1:0]   frame_time     [EYE_COUNT];

   rsp_type expected_delays[$];   // results still owed by the block
   int      mismatches = 0;

   // Idle controls shared by the sender, the receiver and the tests
   bit tx_idle_en = 1'b1;
   bit rx_idle_en = 1'b1;
   bit long_hold_req = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   task automatic clear_delay_model();
      for (int e = 0; e < EYE_COUNT; e++) begin
         for (int s = 0; s < RING_SLOTS; s++) begin
            slot_pts_valid[e][s] = 1'b0;
            slot_pts[e][s]       = '0;
         end
         for (int w = 0; w < WINDOW_SAMPLES; w++)
            delay_hist[e][w] = 0;
         hist_head[e] = 0;
         hist_sum[e]  = 0;
      end
   endtask

   task automatic predict_delay(input req_type r);
      int      e;
      int      fill;
      int      shown;
      longint  ft;
      longint  buffered;
      longint  due;
      longint  sample;
      longint  mean;
      rsp_type want;
      e = int'(r.eye);
      case (r.cmd)
         CMD_CLEAR: begin
            clear_delay_model();
         end
         CMD_RECORD: begin
            if (e < EYE_COUNT && int'(r.slot) < RING_SLOTS) begin
               slot_pts_valid[e][r.slot] = r.frame_pts_valid;
               slot_pts[e][r.slot]       = r.frame_pts_valid ? r.frame_pts : '0;
            end
         end
         CMD_UPDATE: begin
            if (e < EYE_COUNT) begin
               ft   = longint'(frame_time[e]);
               fill = (int'(r.store_index) % RING_SLOTS + RING_SLOTS
                       - int'(r.draw_index) % RING_SLOTS) % RING_SLOTS;
               buffered = fill * ft;
               // add what is left of the frame on screen, if anything
               due = longint'(r.last_frame_time) + ft;
               if (due > longint'(r.now_time))
                  buffered += due - longint'(r.now_time);
               // shown frame is one behind the draw index
               shown = (int'(r.draw_index) % RING_SLOTS + RING_SLOTS - 1) % RING_SLOTS;
               if (slot_pts_valid[e][shown])
                  sample = longint'(r.audio_position) - longint'(slot_pts[e][shown]);
               else
                  sample = longint'(r.audio_position) - longint'(r.video_position)
                           + buffered;
               if (sample > SAMPLE_HI)
                  sample = SAMPLE_HI;
               else if (sample < SAMPLE_LO)
                  sample = SAMPLE_LO;
               hist_sum[e] += sample - delay_hist[e][hist_head[e]];
               delay_hist[e][hist_head[e]] = sample;
               hist_head[e] = (hist_head[e] + 1) % WINDOW_SAMPLES;
               // mean rounds toward minus infinity
               if (hist_sum[e] >= 0)
                  mean = hist_sum[e] / WINDOW_SAMPLES;
               else
                  mean = -((-hist_sum[e] + WINDOW_SAMPLES - 1) / WINDOW_SAMPLES);
               want.result_eye    = r.eye;
               want.delay_sample  = sample[SAMPLE_W-1:0];
               want.average_delay = mean[SAMPLE_W-1:0];
               expected_delays.push_back(want);
            end
         end
         default: ;   // unused command, nothing happens
      endcase
   endtask

   // ------------------------------------------------------------------
   // Item builders
   // ------------------------------------------------------------------
   function automatic logic [TIME_W-1:0] rand_time();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[TIME_W-1:0];
   endfunction

   function automatic logic [NOW_W-1:0] rand_now();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[NOW_W-1:0];
   endfunction

   function automatic req_type random_item();
      req_type     r;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 38)
         r.cmd = CMD_RECORD;
      else if (pick < 96)
         r.cmd = CMD_UPDATE;
      else if (pick < 99)
         r.cmd = CMD_NONE;
      else
         r.cmd = CMD_CLEAR;   // rare, so windows get to wrap
      r.eye             = EYE_BITS'($urandom_range(0, 1));
      r.slot            = SLOT_BITS'($urandom_range(0, RING_SLOTS - 1));
      r.frame_pts       = rand_time();
      r.frame_pts_valid = ($urandom_range(0, 3) != 0);
      r.store_index     = SLOT_BITS'($urandom_range(0, 15));
      r.draw_index      = SLOT_BITS'($urandom_range(0, 15));
      if ($urandom_range(0, 1) == 0) begin
         r.now_time        = rand_now();
         r.last_frame_time = rand_now();
         r.audio_position  = rand_time();
         r.video_position  = rand_time();
      end else begin
         // playback-like: frame due near now, positions close together
         r.last_frame_time = rand_now();
         r.now_time        = r.last_frame_time + NOW_W'($urandom_range(0, 40000));
         r.audio_position  = r.frame_pts + TIME_W'($urandom_range(0, 16000));
         r.video_position  = r.audio_position + TIME_W'($urandom_range(0, 16000))
                             - TIME_W'(8000);
      end
      return r;
   endfunction

   function automatic req_type rec_item(input logic [EYE_BITS-1:0] eye,
                                        input logic [SLOT_BITS-1:0] slot,
                                        input logic [TIME_W-1:0] pts,
                                        input logic pts_ok);
      req_type r;
      r                 = '0;
      r.cmd             = CMD_RECORD;
      r.eye             = eye;
      r.slot            = slot;
      r.frame_pts       = pts;
      r.frame_pts_valid = pts_ok;
      return r;
   endfunction

   function automatic req_type upd_item(input logic [EYE_BITS-1:0] eye,
                                        input logic [SLOT_BITS-1:0] store,
                                        input logic [SLOT_BITS-1:0] draw,
                                        input logic [NOW_W-1:0] now_t,
                                        input logic [NOW_W-1:0] last_t,
                                        input logic [TIME_W-1:0] audio,
                                        input logic [TIME_W-1:0] video);
      req_type r;
      r                 = '0;
      r.cmd             = CMD_UPDATE;
      r.eye             = eye;
      r.store_index     = store;
      r.draw_index      = draw;
      r.now_time        = now_t;
      r.last_frame_time = last_t;
      r.audio_position  = audio;
      r.video_position  = video;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Sender: one item per call, optional idle burst first. Valid stays
   // high across back-to-back calls.
   // ------------------------------------------------------------------
   task automatic send_item(input req_type item);
      int gap;
      gap = 0;
      if (tx_idle_en && $urandom_range(0, 5) == 0)
         gap = $urandom_range(1, 19);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predict_delay(item);
   endtask

   // Normal playback step: record a frame, then update with that frame shown
   task automatic send_frame_pair(input logic [EYE_BITS-1:0] eye);
      req_type rec;
      req_type upd;
      rec                 = random_item();
      rec.cmd             = CMD_RECORD;
      rec.eye             = eye;
      rec.frame_pts_valid = ($urandom_range(0, 7) != 0);
      upd                 = random_item();
      upd.cmd             = CMD_UPDATE;
      upd.eye             = eye;
      upd.draw_index      = SLOT_BITS'((int'(rec.slot) + 1) % RING_SLOTS);
      upd.audio_position  = rec.frame_pts + TIME_W'($urandom_range(0, 16000))
                            - TIME_W'(8000);
      send_item(rec);
      send_item(upd);
   endtask

   // Drop valid and wait until the block owes nothing and its stage is empty
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_delays.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_frame_time(input csr_index_type idx, input int unsigned value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= FT_W'(value);
      frame_time[int'(idx)] = FT_W'(value);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_directed();
      req_type nop;
      // frame times still at reset (zero)
      send_item(upd_item(0, 0, 0, '0, '0, '0, '0));          // all zero
      send_item(upd_item(1, 15, 0, '0, '1, '1, '0));         // huge buffer, saturates high
      send_item(upd_item(0, 0, 0, '1, '0, '0, '1));          // one above the most negative sample
      send_item(upd_item(1, 0, 0, '1, '1, '1, '1));          // frame due exactly now
      wait_idle();
      write_frame_time(CSR_FRAME_TIME_LEFT, 16000);
      write_frame_time(CSR_FRAME_TIME_RIGHT, 1);
      send_item(upd_item(0, 3, 5, 44'd1000, 44'd1000, 35'd500, 35'd400));   // fill wraps
      send_item(upd_item(1, 5, 3, '0, '0, '0, '0));          // part of a frame left
      // draw index zero: shown slot wraps to the top of the ring
      send_item(rec_item(0, 15, '1, 1'b1));
      send_item(upd_item(0, 2, 0, '0, '0, '0, 35'd77));
      send_item(rec_item(1, 3, 35'd5, 1'b1));
      send_item(upd_item(1, 9, 4, 44'd50, 44'd10, 35'd100, 35'd3));
      // invalidated slot falls back to the video position
      send_item(rec_item(1, 3, 35'd77, 1'b0));
      send_item(upd_item(1, 9, 4, 44'd50, 44'd10, 35'd100, 35'd30));
      send_item(rec_item(0, 0, '0, 1'b1));
      send_item(upd_item(0, 0, 1, '0, '0, '1, '0));
      // unused command with busy fields
      nop     = random_item();
      nop.cmd = CMD_NONE;
      send_item(nop);
      send_item(upd_item(0, 0, 1, '0, '0, 35'd9, '0));
      // clear drops slot times and windows
      nop     = random_item();
      nop.cmd = CMD_CLEAR;
      send_item(nop);
      send_item(upd_item(0, 0, 0, '0, '0, 35'd1234, 35'd34));
      // same slot on both eyes stays separate
      send_item(rec_item(1, 7, 35'd1000, 1'b1));
      send_item(rec_item(0, 7, 35'd2000, 1'b1));
      send_item(upd_item(1, 0, 8, '0, '0, 35'd1500, '0));
      send_item(upd_item(0, 0, 8, '0, '0, 35'd1500, '0));
      wait_idle();
   endtask

   task automatic test_frame_times();
      int unsigned left_ft  [4];
      int unsigned right_ft [4];
      left_ft  = '{0, 16000, 16000, $urandom_range(0, 16000)};
      right_ft = '{16000, 0, 16000, $urandom_range(0, 16000)};
      for (int i = 0; i < 4; i++) begin
         wait_idle();
         write_frame_time(CSR_FRAME_TIME_LEFT, left_ft[i]);
         write_frame_time(CSR_FRAME_TIME_RIGHT, right_ft[i]);
         repeat (20) send_frame_pair(EYE_BITS'($urandom_range(0, 1)));
         repeat (20) send_item(random_item());
      end
      wait_idle();
   endtask

   task automatic test_random_traffic();
      write_frame_time(CSR_FRAME_TIME_LEFT, $urandom_range(0, 16000));
      write_frame_time(CSR_FRAME_TIME_RIGHT, $urandom_range(0, 16000));
      // mostly record/update pairs; the rest is loose or broken traffic
      repeat (240) begin
         if ($urandom_range(0, 9) < 6)
            send_frame_pair(EYE_BITS'($urandom_range(0, 1)));
         else
            send_item(random_item());
      end
      wait_idle();
   endtask

   task automatic test_backpressure();
      tx_idle_en    = 1'b0;
      long_hold_req = 1'b1;   // receiver holds off for a long stretch
      repeat (30) send_frame_pair(EYE_BITS'($urandom_range(0, 1)));
      // sender pauses until every result is back
      wait_idle();
      tx_idle_en = 1'b1;
   endtask

   task automatic test_no_idle();
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
      repeat (50) send_frame_pair(EYE_BITS'($urandom_range(0, 1)));
   endtask

   // ------------------------------------------------------------------
   // Receiver: random ready bursts, plus one long hold on request
   // ------------------------------------------------------------------
   initial begin : receiver
      int hold_left;
      int gap_left;
      hold_left = 0;
      gap_left  = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left     = 300;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (gap_left > 0) begin
            rsp_ready <= 1'b0;
            gap_left--;
         end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
            rsp_ready <= 1'b0;
            gap_left  = $urandom_range(0, 18);   // burst of 1..19
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Result checker: each accepted result against the oldest expectation
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_delays.size() == 0) begin
            $display("%0t: unexpected result eye %0d sample %0d mean %0d", $time,
                     rsp_data.result_eye, rsp_data.delay_sample, rsp_data.average_delay);
            mismatches++;
         end else begin
            want = expected_delays.pop_front();
            if (rsp_data.result_eye !== want.result_eye) begin
               $display("%0t: result_eye expected %0d actual %0d", $time,
                        want.result_eye, rsp_data.result_eye);
               mismatches++;
            end
            if (rsp_data.delay_sample !== want.delay_sample) begin
               $display("%0t: delay_sample expected %0d actual %0d", $time,
                        want.delay_sample, rsp_data.delay_sample);
               mismatches++;
            end
            if (rsp_data.average_delay !== want.average_delay) begin
               $display("%0t: average_delay expected %0d actual %0d", $time,
                        want.average_delay, rsp_data.average_delay);
               mismatches++;
            end
         end
      end
   end

   // Hang detector: too long without any item moving on either channel
   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_write_en = 1'b0;
      csr_index    = CSR_FRAME_TIME_LEFT;
      csr_wdata    = '0;
      clear_delay_model();
      for (int e = 0; e < EYE_COUNT; e++)
         frame_time[e] = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_frame_times();
      test_random_traffic();
      test_backpressure();
      test_no_idle();

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && expected_delays.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
